/* design/kmer_minhash_sketch_macros.svh */
// Assertion helpers for the checker file of the sketch block.
// Each macro expects signals named clock and reset in the using scope.
`ifndef KMER_MINHASH_SKETCH_MACROS_SVH
`define KMER_MINHASH_SKETCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KMS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kms: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kms: next-cycle check failed");

`endif

/* design/kms_pkg.sv */
package kms_pkg;

   // Sketch geometry.
   localparam int KMER_LEN  = 5;
   localparam int NUM_SEEDS = 4;

   localparam int  CNT_W  = $clog2(KMER_LEN + 1);
   localparam int  SEED_W = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
   // A k-mer longer than eight bytes also fills the second tail lane.
   localparam bit  HAS_K2 = (KMER_LEN > 8);

   // Hash constants.
   localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
   localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
   localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;

   typedef logic [63:0]       word_type;
   typedef logic [SEED_W-1:0] seed_type;
   typedef logic [CNT_W-1:0]  count_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD_K1,
      OP_LOAD_K2,
      OP_MUL,
      OP_ROT31,
      OP_ROT33,
      OP_STORE_K1,
      OP_STORE_K2,
      OP_SEED_INIT,
      OP_XSHIFT,
      OP_SWAP,
      OP_FINISH,
      OP_EMIT
   } op_type;

   // Multiplier constant selection.
   typedef enum logic [1:0] {
      MC_C1,
      MC_C2,
      MC_F1,
      MC_F2
   } mconst_type;

   // Partial-product step of the 64-bit multiply.
   typedef enum logic [1:0] {
      PH_LL,
      PH_LH,
      PH_HL
   } phase_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_K1_MULA,
      S_K1_ROT,
      S_K1_MULB,
      S_K1_STORE,
      S_K2_LOAD,
      S_K2_MULA,
      S_K2_ROT,
      S_K2_MULB,
      S_K2_STORE,
      S_SEED_INIT,
      S_X0,
      S_MULA,
      S_X1,
      S_MULB,
      S_X2,
      S_SWAP,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef struct packed {
      op_type     op;
      phase_type  phase;
      mconst_type mconst;
      seed_type   seed;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic out_free;
   } status_type;

endpackage

/* design/kms_if.sv */
// Input channel: one sequence character per item.
interface kms_req_if import kms_pkg::*;;
   logic       valid;
   logic       ready;
   logic [7:0] base_char;
   logic       last_char;

   modport source (output valid, base_char, last_char, input ready);
   modport sink   (input valid, base_char, last_char, output ready);
endinterface

// Result channel: one per-seed minimum per item.
interface kms_rsp_if import kms_pkg::*;;
   logic       valid;
   logic       ready;
   logic [1:0] seed_index;
   word_type   min_word;
   logic       valid_res;
   logic       last_result;

   modport source (output valid, seed_index, min_word, valid_res, last_result, input ready);
   modport sink   (input valid, seed_index, min_word, valid_res, last_result, output ready);
endinterface

/* design/kmer_minhash_sketch.sv */
// Channel | Dir | Payload                                         | Item
// req_ch  | in  | base_char[7:0], last_char                       | one character
// rsp_ch  | out | seed_index[1:0], min_word[63:0], valid_res,     | one seed minimum
//         |     | last_result                                     |
//
// A character that does not complete a k-mer only shifts the window. Once the window is full,
// each character is hashed once per seed on the single shared 32x32 multiplier, which
// needs three steps for each 64-bit product; a new character is taken only when idle.
// A last character adds NUM_SEEDS result items, each held while the result side stalls.
// The result register lets the next character enter while the final result waits.
// Synchronous active-high reset clears the count, the minima and all handshake state.
module kmer_minhash_sketch import kms_pkg::*; (
   input logic      clock,
   input logic      reset,
   kms_req_if.sink  req_ch,
   kms_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   kms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, hash unit, minima and result register.
   kms_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .base_char       (req_ch.base_char),
      .last_char       (req_ch.last_char),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_seed_index  (rsp_ch.seed_index),
      .rsp_min_word    (rsp_ch.min_word),
      .rsp_valid_res   (rsp_ch.valid_res),
      .rsp_last_result (rsp_ch.last_result)
   );

endmodule

/* design/kms_datapath.sv */
module kms_datapath import kms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] base_char,
   input  logic       last_char,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic [1:0] rsp_seed_index,
   output word_type   rsp_min_word,
   output logic       rsp_valid_res,
   output logic       rsp_last_result
);

   logic [7:0] window_ff [KMER_LEN];
   logic [7:0] window_in [KMER_LEN];
   count_type  count_ff, count_in;
   logic       last_ff, last_in;
   word_type   acc_ff, acc_in;
   word_type   prod_ff, prod_in;
   word_type   k1m_ff, k1m_in;
   word_type   k2m_ff, k2m_in;
   word_type   ha_ff, ha_in;
   word_type   hb_ff, hb_in;
   word_type   min_ff [NUM_SEEDS];
   word_type   min_in [NUM_SEEDS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_seed_ff, rsp_seed_in;
   word_type   rsp_hash_ff, rsp_hash_in;
   logic       rsp_vres_ff, rsp_vres_in;
   logic       rsp_last_ff, rsp_last_in;

   word_type    k_raw1, k_raw2;
   word_type    kconst;
   logic [31:0] mul_a, mul_b;
   word_type    mul_p;
   word_type    h1_init, h2_init, seed_word, len_word;
   word_type    hash_sum, min_sel;
   logic        full, seed_last;

   // Tail words of the k-mer, oldest character in the lowest byte.
   always_comb begin
      k_raw1 = '0;
      k_raw2 = '0;
      for (int i = 0; i < KMER_LEN; i++) begin
         if (i < 8) begin
            k_raw1 |= word_type'(window_ff[i]) << (8 * i);
         end else begin
            k_raw2 |= word_type'(window_ff[i]) << (8 * (i - 8));
         end
      end
   end

   // Shared 32 x 32 multiplier; a 64-bit low product takes three steps.
   always_comb begin
      unique case (cmd.mconst)
         MC_C1:   kconst = MM_C1;
         MC_C2:   kconst = MM_C2;
         MC_F1:   kconst = FMIX_M1;
         default: kconst = FMIX_M2;
      endcase
      mul_a = (cmd.phase == PH_HL) ? acc_ff[63:32] : acc_ff[31:0];
      mul_b = (cmd.phase == PH_LH) ? kconst[63:32] : kconst[31:0];
      mul_p = mul_a * mul_b;
   end

   // Seeded state words and the final sum of both halves.
   assign seed_word = word_type'(cmd.seed);
   assign len_word  = word_type'(KMER_LEN);
   assign h1_init   = seed_word ^ k1m_ff ^ len_word;
   assign h2_init   = seed_word ^ (HAS_K2 ? k2m_ff : '0) ^ len_word;
   assign hash_sum  = ha_ff + acc_ff;
   assign min_sel   = min_ff[cmd.seed];
   assign full      = (count_ff == CNT_W'(KMER_LEN));
   assign seed_last = (cmd.seed == SEED_W'(NUM_SEEDS - 1));

   // Next-value logic for every register, selected by the command.
   always_comb begin
      window_in    = window_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      k1m_in       = k1m_ff;
      k2m_in       = k2m_ff;
      ha_in        = ha_ff;
      hb_in        = hb_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_seed_in  = rsp_seed_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_vres_in  = rsp_vres_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (cmd.op)
         OP_ACCEPT: begin
            for (int i = 0; i < KMER_LEN - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[KMER_LEN - 1] = base_char;
            last_in = last_char;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_LOAD_K1: acc_in = k_raw1;
         OP_LOAD_K2: acc_in = k_raw2;
         OP_MUL: begin
            case (cmd.phase)
               PH_LL:   prod_in = mul_p;
               PH_LH:   prod_in = prod_ff + {mul_p[31:0], 32'b0};
               PH_HL:   acc_in  = prod_ff + {mul_p[31:0], 32'b0};
               default: ;
            endcase
         end
         OP_ROT31:    acc_in = {acc_ff[32:0], acc_ff[63:33]};
         OP_ROT33:    acc_in = {acc_ff[30:0], acc_ff[63:31]};
         OP_STORE_K1: k1m_in = acc_ff;
         OP_STORE_K2: k2m_in = acc_ff;
         OP_SEED_INIT: begin
            acc_in = h1_init + h2_init;
            ha_in  = h1_init + h2_init;
            hb_in  = h2_init;
         end
         OP_XSHIFT: acc_in = acc_ff ^ {33'b0, acc_ff[63:33]};
         OP_SWAP: begin
            // Keep the mixed first half; the second half is h2 plus the first sum.
            ha_in  = acc_ff;
            acc_in = hb_ff + ha_ff;
         end
         OP_FINISH: begin
            if (hash_sum < min_sel) begin
               min_in[cmd.seed] = hash_sum;
            end
         end
         OP_EMIT: begin
            rsp_valid_in     = 1'b1;
            rsp_seed_in      = 2'(cmd.seed);
            rsp_hash_in      = full ? min_sel : '0;
            rsp_vres_in      = full;
            rsp_last_in      = seed_last;
            min_in[cmd.seed] = '1;
            if (seed_last) begin
               count_in = '0;
            end
         end
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SEEDS; s++) begin
            min_ff[s] <= '1;
         end
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      k1m_ff      <= k1m_in;
      k2m_ff      <= k2m_in;
      ha_ff       <= ha_in;
      hb_ff       <= hb_in;
      rsp_seed_ff <= rsp_seed_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_vres_ff <= rsp_vres_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.full     = full;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seed_index  = rsp_seed_ff;
   assign rsp_min_word    = rsp_hash_ff;
   assign rsp_valid_res   = rsp_vres_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

/* design/kms_ctrl.sv */
module kms_ctrl import kms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   seed_type  seed_ff, seed_in;
   logic      second_ff, second_in;
   logic      mul_done;

   assign mul_done = (phase_ff == PH_HL);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_LL;
         seed_ff   <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         seed_ff   <= seed_in;
         second_ff <= second_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      seed_in    = seed_ff;
      second_in  = second_ff;
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.phase  = phase_ff;
      cmd.mconst = MC_C1;
      cmd.seed   = seed_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.full) begin
               cmd.op   = OP_LOAD_K1;
               state_in = S_K1_MULA;
            end else begin
               state_in = status.last ? S_EMIT : S_IDLE;
            end
         end
         S_K1_MULA: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_C1;
            if (mul_done) state_in = S_K1_ROT;
         end
         S_K1_ROT: begin
            cmd.op   = OP_ROT31;
            state_in = S_K1_MULB;
         end
         S_K1_MULB: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_C2;
            if (mul_done) state_in = S_K1_STORE;
         end
         S_K1_STORE: begin
            cmd.op   = OP_STORE_K1;
            state_in = HAS_K2 ? S_K2_LOAD : S_SEED_INIT;
         end
         S_K2_LOAD: begin
            cmd.op   = OP_LOAD_K2;
            state_in = S_K2_MULA;
         end
         S_K2_MULA: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_C2;
            if (mul_done) state_in = S_K2_ROT;
         end
         S_K2_ROT: begin
            cmd.op   = OP_ROT33;
            state_in = S_K2_MULB;
         end
         S_K2_MULB: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_C1;
            if (mul_done) state_in = S_K2_STORE;
         end
         S_K2_STORE: begin
            cmd.op   = OP_STORE_K2;
            state_in = S_SEED_INIT;
         end
         S_SEED_INIT: begin
            cmd.op    = OP_SEED_INIT;
            second_in = 1'b0;
            state_in  = S_X0;
         end
         S_X0: begin
            cmd.op   = OP_XSHIFT;
            state_in = S_MULA;
         end
         S_MULA: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_F1;
            if (mul_done) state_in = S_X1;
         end
         S_X1: begin
            cmd.op   = OP_XSHIFT;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.op     = OP_MUL;
            cmd.mconst = MC_F2;
            if (mul_done) state_in = S_X2;
         end
         S_X2: begin
            cmd.op   = OP_XSHIFT;
            state_in = second_ff ? S_FINISH : S_SWAP;
         end
         S_SWAP: begin
            cmd.op    = OP_SWAP;
            second_in = 1'b1;
            state_in  = S_X0;
         end
         S_FINISH: begin
            cmd.op = OP_FINISH;
            if (seed_ff == SEED_W'(NUM_SEEDS - 1)) begin
               seed_in  = '0;
               state_in = status.last ? S_EMIT : S_IDLE;
            end else begin
               seed_in  = seed_ff + 1'b1;
               state_in = S_SEED_INIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (seed_ff == SEED_W'(NUM_SEEDS - 1)) begin
                  seed_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  seed_in = seed_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Step through the partial products while a multiply runs.
   always_comb begin
      phase_in = PH_LL;
      if (cmd.op == OP_MUL) begin
         case (phase_ff)
            PH_LL:   phase_in = PH_LH;
            PH_LH:   phase_in = PH_HL;
            default: phase_in = PH_LL;
         endcase
      end
   end

endmodule

/* design/kms_checker.sv */
`include "kmer_minhash_sketch_macros.svh"

module kms_checker import kms_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_seed_index,
   input word_type   rsp_min_word,
   input logic       rsp_valid_res,
   input logic       rsp_last_result
);

   localparam logic [1:0] LAST_IDX = 2'(NUM_SEEDS - 1);

   logic [1:0]  exp_ff, exp_in;
   logic [67:0] rsp_payload;

   // All result fields side by side, for the hold check.
   assign rsp_payload = {rsp_seed_index, rsp_min_word, rsp_valid_res, rsp_last_result};

   // Seed index expected on the next result item.
   always_comb begin
      exp_in = exp_ff;
      if (rsp_valid && rsp_ready) begin
         exp_in = rsp_last_result ? 2'b0 : rsp_seed_index + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= 2'b0;
      end else begin
         exp_ff <= exp_in;
      end
   end

   // A stalled result item holds.
   `KMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // A short sequence reports a zero minimum.
   `KMS_ASSERT_IMP(a_short_zero, rsp_valid && !rsp_valid_res, rsp_min_word == '0)
   // Seeds come out in order, restarting after each final item.
   `KMS_ASSERT_IMP(a_seed_order, rsp_valid, rsp_seed_index == exp_ff)
   // The final item of a sequence belongs to the highest seed.
   `KMS_ASSERT_IMP(a_last_seed, rsp_valid && rsp_last_result, rsp_seed_index == LAST_IDX)

endmodule

bind kmer_minhash_sketch kms_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_seed_index  (rsp_ch.seed_index),
   .rsp_min_word    (rsp_ch.min_word),
   .rsp_valid_res   (rsp_ch.valid_res),
   .rsp_last_result (rsp_ch.last_result)
);
